@@ rtl/rsq_pkg.sv @@
// Package for the rounded integer square root block.
// Holds the per-stage control struct and the digit-step tail constants.
// No dependencies.
package rsq_pkg;

  // Control bits that travel down the pipeline with each transaction.
  typedef struct packed {
    logic valid;
    logic last;
  } rsq_ctl_t;

  // Low bits appended to the shifted partial root in a digit step.
  localparam logic [1:0] ADD_TAIL = 2'b11;
  localparam logic [1:0] SUB_TAIL = 2'b01;

endpackage

@@ rtl/rsq_stage.sv @@
// One registered non-restoring square root digit step.
// Depends on rsq_pkg for the control struct and tail constants.
module rsq_stage #(
  parameter int STEPS = 16,
  parameter int RW    = 20,
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  rsq_pkg::rsq_ctl_t     ctl_in,
  input  logic [2*STEPS-1:0]    rad_in,
  input  logic [RW-1:0]         r_in,
  input  logic [STEPS-1:0]      q_in,
  output rsq_pkg::rsq_ctl_t     ctl_out,
  output logic [2*STEPS-1:0]    rad_out,
  output logic [RW-1:0]         r_out,
  output logic [STEPS-1:0]      q_out
);
  import rsq_pkg::*;

  // Radicand pair consumed by this stage, most significant pair first.
  localparam int PAIR = STEPS - 1 - STAGE;

  logic [1:0]       pair;
  logic             neg;
  logic [RW-1:0]    r_sh;
  logic [RW-1:0]    q_term;
  logic [RW-1:0]    r_next;
  logic [STEPS-1:0] q_next;

  // Bring down two bits, then add or subtract the shifted root.
  always_comb begin
    pair   = rad_in[2*PAIR+1 -: 2];
    neg    = r_in[RW-1];
    r_sh   = {r_in[RW-3:0], pair};
    q_term = RW'({q_in, (neg ? ADD_TAIL : SUB_TAIL)});
    r_next = neg ? (r_sh + q_term) : (r_sh - q_term);
    q_next = {q_in[STEPS-2:0], ~r_next[RW-1]};
  end

  // Valid bit is reset; payload registers load whenever the stage advances.
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_out.last <= ctl_in.last;
      rad_out      <= rad_in;
      r_out        <= r_next;
      q_out        <= q_next;
    end
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (adv) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

endmodule

@@ rtl/rounded_integer_square_root_top.sv @@
// Rounded integer square root: returns the radicand's square root rounded to
// the nearest integer, with last_out copied from last_in. The block is a
// pipeline of (RADICAND_BITS+1)/2 digit-step stages, one non-restoring step
// per stage, followed by a remainder correction stage and a rounding stage.
// One transaction is accepted every cycle; a stall on the output lets empty
// stages fill up before in_ready drops.
// Depends on rsq_pkg and rsq_stage.
module rounded_integer_square_root_top #(
  parameter int RADICAND_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [RADICAND_BITS-1:0]         radicand,
  input  logic                             last_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [(RADICAND_BITS+1)/2:0]     root,
  output logic                             last_out
);
  import rsq_pkg::*;

  localparam int STEPS     = (RADICAND_BITS + 1) / 2;
  localparam int ROOT_BITS = STEPS + 1;
  localparam int RADW      = 2 * STEPS;
  localparam int RW        = STEPS + 4;

  rsq_ctl_t         ctl [0:STEPS];
  logic [RADW-1:0]  rad [0:STEPS];
  logic [RW-1:0]    rem [0:STEPS];
  logic [STEPS-1:0] q   [0:STEPS];
  logic             adv [0:STEPS-1];

  // Correction stage and rounding stage registers.
  rsq_ctl_t         fa_ctl;
  logic [RW-1:0]    fa_rem;
  logic [STEPS-1:0] fa_q;
  logic             fa_adv;
  logic             fb_adv;
  logic [RW-1:0]    rem_fix;
  logic [ROOT_BITS-1:0] root_next;

  // Pipeline entry.
  assign ctl[0].valid = in_valid;
  assign ctl[0].last  = last_in;
  assign rad[0]       = RADW'(radicand);
  assign rem[0]       = '0;
  assign q[0]         = '0;

  // A stage advances when it is empty or the stage after it advances.
  assign fb_adv = ~out_valid | out_ready;
  assign fa_adv = ~fa_ctl.valid | fb_adv;
  assign in_ready = adv[0];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    if (k == STEPS - 1) begin : g_tail
      assign adv[k] = ~ctl[k+1].valid | fa_adv;
    end else begin : g_mid
      assign adv[k] = ~ctl[k+1].valid | adv[k+1];
    end

    rsq_stage #(
      .STEPS (STEPS),
      .RW    (RW),
      .STAGE (k)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv[k]),
      .ctl_in  (ctl[k]),
      .rad_in  (rad[k]),
      .r_in    (rem[k]),
      .q_in    (q[k]),
      .ctl_out (ctl[k+1]),
      .rad_out (rad[k+1]),
      .r_out   (rem[k+1]),
      .q_out   (q[k+1])
    );
  end

  // Correction stage: make a negative remainder non-negative.
  always_ff @(posedge clk) begin
    if (fa_adv) begin
      fa_ctl.last <= ctl[STEPS].last;
      fa_q        <= q[STEPS];
      fa_rem      <= rem[STEPS][RW-1] ?
                     (rem[STEPS] + RW'({q[STEPS], 1'b1})) : rem[STEPS];
    end
    if (rst) begin
      fa_ctl.valid <= 1'b0;
    end else if (fa_adv) begin
      fa_ctl.valid <= ctl[STEPS].valid;
    end
  end

  // Rounding stage: round up when the remainder exceeds the floor root.
  always_comb begin
    rem_fix   = fa_rem;
    root_next = ROOT_BITS'(fa_q) + ROOT_BITS'(rem_fix > RW'(fa_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fb_adv) begin
      out_valid <= fa_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fb_adv) begin
      root     <= root_next;
      last_out <= fa_ctl.last;
    end
  end

  // The rounded root never exceeds 2^STEPS.
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (root <= {1'b1, {STEPS{1'b0}}}))
    else $error("root out of range");

  // After correction the remainder is non-negative.
  a_rem_nonneg: assert property (@(posedge clk) disable iff (rst)
    fa_ctl.valid |-> !fa_rem[RW-1])
    else $error("corrected remainder negative");

  // The true remainder is bounded by twice the floor root.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    fa_ctl.valid |-> (fa_rem <= RW'({fa_q, 1'b0})))
    else $error("remainder above 2q");

  // Input back-pressure only when the output is stalled.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && fa_ctl.valid))
    else $error("in_ready low without a full stalled pipeline");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for rounded_integer_square_root_top.
// Drives radicands through a valid/ready driver and checks root and last_out
// against a bit-accurate predictor. Depends only on the RTL of the block.
`timescale 1ns / 100ps

module tb;

  localparam int RAD_W      = 32;
  localparam int ROOT_W     = (RAD_W + 1) / 2 + 1;
  localparam int RANDOM_CNT = 1700;
  localparam int QUIET_TAIL = 250;
  localparam int DRAIN_WAIT = 40;
  localparam int CYCLE_MAX  = 600000;

  // One pending transaction on the input side.
  typedef struct {
    logic [RAD_W-1:0] value;
    logic             last;
    int unsigned      gap;
    bit               hold;
  } rad_item_t;

  // One expected transaction on the output side.
  typedef struct {
    logic [ROOT_W-1:0] root;
    logic              last;
  } root_exp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [RAD_W-1:0]  radicand = '0;
  logic              last_in = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ROOT_W-1:0] root;
  logic              last_out;

  rad_item_t   rad_q[$];
  root_exp_t   root_q[$];
  rad_item_t   next_item;
  root_exp_t   pred;
  root_exp_t   want;
  int unsigned lead_cnt;
  int unsigned stall_left;
  bit          sink_stall_en;
  int unsigned total_cnt;
  int unsigned sent_cnt;
  int unsigned checked_cnt;
  int unsigned round_up_cnt;
  int unsigned vec_end_cnt;
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  rounded_integer_square_root_top #(
    .RADICAND_BITS(RAD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .radicand(radicand),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .root(root),
    .last_out(last_out)
  );

  always #4 clk = ~clk;

  // Square root rounded to nearest: find the floor root bit by bit, then
  // round up when the leftover exceeds the floor root.
  function automatic logic [ROOT_W-1:0] nearest_root(logic [RAD_W-1:0] d);
    longint unsigned q;
    longint unsigned t;
    q = 0;
    for (int b = ROOT_W - 2; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t * t <= d)
        q = t;
    end
    if (d - q * q > q)
      q = q + 1;
    return q[ROOT_W-1:0];
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic add_item(logic [RAD_W-1:0] value, logic last, int unsigned gap,
                          bit hold);
    rad_item_t it;
    it.value = value;
    it.last  = last;
    it.gap   = gap;
    it.hold  = hold;
    rad_q.push_back(it);
  endtask

  // Picks a radicand from one of several regions of the input range.
  function automatic logic [RAD_W-1:0] pick_radicand();
    longint unsigned k;
    longint unsigned v;
    int unsigned     kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      v = $urandom;
    end else if (kind < 62) begin
      // Near a perfect square or near a rounding boundary.
      k = $urandom_range(0, 65535);
      case ($urandom_range(0, 4))
        0: v = (k == 0) ? 0 : k * k - 1;
        1: v = k * k;
        2: v = k * k + k;
        3: v = k * k + k + 1;
        default: v = k * k + $urandom_range(0, 2 * k);
      endcase
      if (v > 64'hFFFF_FFFF)
        v = 64'hFFFF_FFFF;
    end else if (kind < 75) begin
      v = $urandom_range(0, 1023);
    end else if (kind < 85) begin
      v = {16'hFFFF, 16'($urandom)};
    end else begin
      v = $urandom >> $urandom_range(0, 31);
    end
    return v[RAD_W-1:0];
  endfunction

  // Input driver: presents queued transactions, honoring each item's lead
  // gap and, for hold items, waiting until every expected result is back.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      lead_cnt = 0;
    end else begin
      if (in_valid && in_ready) begin
        pred.root = nearest_root(radicand);
        pred.last = last_in;
        root_q.push_back(pred);
        if (longint'(pred.root) * longint'(pred.root) > longint'(radicand))
          round_up_cnt++;
        if (last_in)
          vec_end_cnt++;
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (rad_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (lead_cnt < rad_q[0].gap) begin
          lead_cnt++;
          in_valid <= 1'b0;
        end else if (rad_q[0].hold && root_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          next_item = rad_q.pop_front();
          radicand <= next_item.value;
          last_in  <= next_item.last;
          in_valid <= 1'b1;
          lead_cnt = 0;
        end
      end
    end
  end

  // Output monitor: checks each accepted transaction against the oldest
  // expectation and applies random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (root_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: root=%0d last=%0b",
                                    root, last_out));
        end else begin
          want = root_q.pop_front();
          if (root !== want.root)
            report_mismatch($sformatf("root got %0d, expected %0d", root, want.root));
          if (last_out !== want.last)
            report_mismatch($sformatf("last_out got %0b, expected %0b",
                                      last_out, want.last));
          checked_cnt++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_cnt, root_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus build, reset, and end-of-run sequencing.
  initial begin
    int unsigned gap;
    bit          quiet;
    sink_stall_en = 1'b0;

    // Directed part: extremes, small values, and both sides of rounding
    // boundaries, including the smallest and largest radicands that round to 2^16.
    add_item(32'd0,          1'b0, 0, 0);
    add_item(32'd1,          1'b1, 0, 0);
    add_item(32'd2,          1'b0, 0, 0);
    add_item(32'd3,          1'b0, 0, 0);
    add_item(32'd4,          1'b1, 0, 0);
    add_item(32'd6,          1'b0, 0, 0);
    add_item(32'd7,          1'b0, 0, 0);
    add_item(32'd8,          1'b0, 0, 0);
    add_item(32'd9,          1'b1, 0, 0);
    add_item(32'd110,        1'b0, 0, 0);
    add_item(32'd111,        1'b0, 0, 0);
    add_item(32'hFFFF_FFFF,  1'b1, 0, 0);
    add_item(32'hFFFF_0001,  1'b0, 0, 0);
    add_item(32'hFFFF_0000,  1'b0, 0, 0);
    add_item(32'hFFFE_0001,  1'b1, 0, 0);
    add_item(32'hFFFE_0000,  1'b0, 0, 0);
    add_item(32'h8000_0000,  1'b0, 0, 0);
    add_item(32'h4000_0000,  1'b1, 0, 0);
    add_item(32'h3FFF_FFFF,  1'b0, 0, 0);
    add_item(32'hAAAA_AAAA,  1'b0, 0, 0);
    add_item(32'h5555_5555,  1'b1, 0, 0);
    add_item(32'h0001_0000,  1'b0, 0, 0);
    add_item(32'h0000_FFFF,  1'b1, 0, 0);

    // Random part: idle gaps come and go in stretches and stop near the end;
    // every few hundred items the sender waits for the pipeline to drain.
    for (int i = 0; i < RANDOM_CNT; i++) begin
      quiet = ((i / 150) % 4 == 3) || (i >= RANDOM_CNT - QUIET_TAIL);
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      add_item(pick_radicand(), ($urandom_range(0, 7) == 0), gap,
               (i % 400 == 200));
    end
    total_cnt = rad_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Back-pressure follows the same pattern: on, off in stretches, off at
    // the end.
    while (sent_cnt < total_cnt) begin
      @(negedge clk);
      sink_stall_en = (sent_cnt + QUIET_TAIL < total_cnt) && ((sent_cnt / 200) % 3 != 2);
    end
    sink_stall_en = 1'b0;
    while (root_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d radicands (%0d vector ends), checked %0d roots, %0d rounded up.",
             sent_cnt, vec_end_cnt, checked_cnt, round_up_cnt);
    $display("Covered zero, full scale, perfect squares and both sides of each half-step.");
    if (err_cnt == 0 && root_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
